// ----- rtl/pga_pkg.sv -----
// shared widths, codes and types of the pairwise gravity accelerator
package pga_pkg;

	localparam int POS_W  = 32;
	localparam int MASS_W = 48;
	localparam int G_W    = 32;
	localparam int D_W    = 33;
	localparam int S_W    = 66;
	localparam int T_W    = 49;
	localparam int GM_W   = 80;
	localparam int NUM_W  = 113;
	localparam int DEN_W  = 115;
	localparam int Q_W    = 33;
	localparam int CMP_W  = DEN_W + Q_W;
	localparam int SQ_RW  = 53;
	localparam int ACC_W  = 32;
	localparam int N_COMP = 4;

	localparam int SQ_LAT  = T_W;
	localparam int DIV_LAT = Q_W + 2;

	localparam int IN_W  = 2 * (2 * POS_W + MASS_W);
	localparam int OUT_W = N_COMP * ACC_W;

	localparam logic [G_W-1:0] GRAV_RESET = 32'd1231191000;

	typedef enum logic [0:0] {
		REG_GRAV = 1'b0
	} pga_reg_t;

	typedef struct packed {
		logic              valid;
		logic              coinc;
		logic              dx_neg;
		logic              dx_pos;
		logic              dy_neg;
		logic              dy_pos;
		logic [MASS_W-1:0] ma;
		logic [MASS_W-1:0] mb;
		logic [D_W-1:0]    adx;
		logic [D_W-1:0]    ady;
		logic [S_W-1:0]    s;
	} pga_side_t;

	typedef struct packed {
		logic valid;
		logic coinc;
	} pga_tag_t;

endpackage

// ----- rtl/pga_sqrt.sv -----
// pipelined digit-by-digit square root of s * 2^32, one root bit per stage
module pga_sqrt import pga_pkg::*; (
	input  logic           clk,
	input  logic           en,
	input  logic [S_W-1:0] sq_in,
	output logic [T_W-1:0] root
);

	logic [S_W-1:0]   v_s    [SQ_LAT];
	logic [SQ_RW-1:0] rem_s  [SQ_LAT];
	logic [T_W-1:0]   root_s [SQ_LAT];

	genvar i;
	for (i = 0; i < SQ_LAT; i++) begin : g_st
		logic [S_W-1:0]    v_in;
		logic [SQ_RW-1:0]  rem_in;
		logic [T_W-1:0]    root_in;
		logic [S_W+31:0]   vext;
		logic [SQ_RW-1:0]  sh;
		logic [SQ_RW-1:0]  trial;

		if (i == 0) begin : g_first
			assign v_in    = sq_in;
			assign rem_in  = '0;
			assign root_in = '0;
		end else begin : g_next
			assign v_in    = v_s[i-1];
			assign rem_in  = rem_s[i-1];
			assign root_in = root_s[i-1];
		end

		assign vext  = {v_in, 32'b0};
		assign sh    = {rem_in[SQ_RW-3:0], vext[S_W+31-2*i -: 2]};
		assign trial = {{(SQ_RW-T_W-2){1'b0}}, root_in, 2'b01};

		always_ff @(posedge clk) begin
			if (en) begin
				v_s[i] <= v_in;
				if (sh >= trial) begin
					rem_s[i]  <= sh - trial;
					root_s[i] <= {root_in[T_W-2:0], 1'b1};
				end else begin
					rem_s[i]  <= sh;
					root_s[i] <= {root_in[T_W-2:0], 1'b0};
				end
			end
		end
	end

	assign root = root_s[SQ_LAT-1];

endmodule

// ----- rtl/pga_div.sv -----
// pipelined restoring divider with saturation and sign, one quotient bit per stage
module pga_div import pga_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	input  logic             neg,
	output logic [ACC_W-1:0] acc
);

	logic [NUM_W-1:0] rem_s [Q_W+1];
	logic [DEN_W-1:0] den_s [Q_W+1];
	logic [Q_W-1:0]   q_s   [Q_W+1];
	logic             neg_s [Q_W+1];
	logic             sat_s [Q_W+1];
	logic [ACC_W-1:0] acc_q;

	// quotient of 2^33 or more saturates regardless of sign
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= num;
			den_s[0] <= den;
			q_s[0]   <= '0;
			neg_s[0] <= neg;
			sat_s[0] <= {{(CMP_W-NUM_W){1'b0}}, num} >= {den, {Q_W{1'b0}}};
		end
	end

	genvar j;
	for (j = 0; j < Q_W; j++) begin : g_bit
		localparam int K = Q_W - 1 - j;
		logic [CMP_W-1:0] dsh;
		logic             ge;
		logic [Q_W-1:0]   qn;

		assign dsh = {{Q_W{1'b0}}, den_s[j]} << K;
		assign ge  = {{(CMP_W-NUM_W){1'b0}}, rem_s[j]} >= dsh;

		always_comb begin
			qn    = q_s[j];
			qn[K] = ge;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1] <= ge ? rem_s[j] - dsh[NUM_W-1:0] : rem_s[j];
				den_s[j+1] <= den_s[j];
				q_s[j+1]   <= qn;
				neg_s[j+1] <= neg_s[j];
				sat_s[j+1] <= sat_s[j];
			end
		end
	end

	logic [Q_W-1:0]   q_fin;
	logic [ACC_W-1:0] mag;
	logic [ACC_W-1:0] res;

	assign q_fin = q_s[Q_W];

	always_comb begin
		if (sat_s[Q_W] || q_fin > {2'b01, {(Q_W-2){1'b0}}}) begin
			mag = {1'b1, {(ACC_W-1){1'b0}}};
		end else begin
			mag = q_fin[ACC_W-1:0];
		end
		if (neg_s[Q_W]) begin
			res = ~mag + 1'b1;
		end else if (mag[ACC_W-1]) begin
			res = {1'b0, {(ACC_W-1){1'b1}}};
		end else begin
			res = mag;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			acc_q <= res;
		end
	end

	assign acc = acc_q;

endmodule

// ----- rtl/pairwise_gravity_accel_top.sv -----
// top level of the pairwise gravity accelerator: config register, pipeline and stream ports
//
// Takes one body pair per transfer and returns the Q16.16 acceleration of each
// body toward the other, saturated, with coincident set and all fields zero when
// the positions match. One pair is accepted every cycle while the output is taken;
// each result passes through the 49 square-root stages and the 35 divider stages on its
// way to the output register. A stall on the output holds every stage in place.
module pairwise_gravity_accel_top import pga_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [2:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  logic             s_tvalid,
	output logic             s_tready,
	// pos_a_x, pos_a_y, mass_a, pos_b_x, pos_b_y, mass_b
	input  logic [IN_W-1:0]  s_tdata,
	output logic             m_tvalid,
	input  logic             m_tready,
	// acc_a_x, acc_a_y, acc_b_x, acc_b_y
	output logic [OUT_W-1:0] m_tdata,
	// coincident
	output logic             m_tuser
);

	logic [G_W-1:0] grav_q;
	logic           reg_hit;

	assign reg_hit = pga_reg_t'(paddr[2]) == REG_GRAV;
	assign pready  = 1'b1;
	assign prdata  = reg_hit ? grav_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grav_q <= GRAV_RESET;
		end else if (psel && penable && pwrite && reg_hit) begin
			grav_q <= pwdata;
		end
	end

	logic en;
	logic out_v_q;

	assign en       = !out_v_q || m_tready;
	assign s_tready = en;

	// stage 1: input capture
	logic              v_s1;
	logic [POS_W-1:0]  pax_s1, pay_s1, pbx_s1, pby_s1;
	logic [MASS_W-1:0] ma_s1, mb_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pax_s1 <= s_tdata[31:0];
			pay_s1 <= s_tdata[63:32];
			ma_s1  <= s_tdata[111:64];
			pbx_s1 <= s_tdata[143:112];
			pby_s1 <= s_tdata[175:144];
			mb_s1  <= s_tdata[223:176];
		end
	end

	// stage 2: differences and magnitudes
	logic [D_W-1:0]    dx, dy;
	logic              v_s2, coinc_s2, dxn_s2, dxp_s2, dyn_s2, dyp_s2;
	logic [D_W-1:0]    adx_s2, ady_s2;
	logic [MASS_W-1:0] ma_s2, mb_s2;

	assign dx = {pbx_s1[POS_W-1], pbx_s1} - {pax_s1[POS_W-1], pax_s1};
	assign dy = {pby_s1[POS_W-1], pby_s1} - {pay_s1[POS_W-1], pay_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			coinc_s2 <= dx == '0 && dy == '0;
			dxn_s2   <= dx[D_W-1];
			dxp_s2   <= !dx[D_W-1] && dx != '0;
			dyn_s2   <= dy[D_W-1];
			dyp_s2   <= !dy[D_W-1] && dy != '0;
			adx_s2   <= dx[D_W-1] ? -dx : dx;
			ady_s2   <= dy[D_W-1] ? -dy : dy;
			ma_s2    <= ma_s1;
			mb_s2    <= mb_s1;
		end
	end

	// stage 3: squares
	logic              v_s3, coinc_s3, dxn_s3, dxp_s3, dyn_s3, dyp_s3;
	logic [D_W-1:0]    adx_s3, ady_s3;
	logic [MASS_W-1:0] ma_s3, mb_s3;
	logic [S_W-1:0]    sx_s3, sy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			coinc_s3 <= coinc_s2;
			dxn_s3   <= dxn_s2;
			dxp_s3   <= dxp_s2;
			dyn_s3   <= dyn_s2;
			dyp_s3   <= dyp_s2;
			adx_s3   <= adx_s2;
			ady_s3   <= ady_s2;
			ma_s3    <= ma_s2;
			mb_s3    <= mb_s2;
			sx_s3    <= S_W'(adx_s2) * S_W'(adx_s2);
			sy_s3    <= S_W'(ady_s2) * S_W'(ady_s2);
		end
	end

	// stage 4: squared distance
	pga_side_t side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s4 <= '0;
		end else if (en) begin
			side_s4.valid  <= v_s3;
			side_s4.coinc  <= coinc_s3;
			side_s4.dx_neg <= dxn_s3;
			side_s4.dx_pos <= dxp_s3;
			side_s4.dy_neg <= dyn_s3;
			side_s4.dy_pos <= dyp_s3;
			side_s4.ma     <= ma_s3;
			side_s4.mb     <= mb_s3;
			side_s4.adx    <= adx_s3;
			side_s4.ady    <= ady_s3;
			side_s4.s      <= sx_s3 + sy_s3;
		end
	end

	// square root with the rest of the item riding alongside
	logic [T_W-1:0] root;
	pga_side_t      side_d [SQ_LAT];

	pga_sqrt u_sqrt (
		.clk   (clk),
		.en    (en),
		.sq_in (side_s4.s),
		.root  (root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SQ_LAT; i++) begin
				side_d[i] <= '0;
			end
		end else if (en) begin
			side_d[0] <= side_s4;
			for (int i = 1; i < SQ_LAT; i++) begin
				side_d[i] <= side_d[i-1];
			end
		end
	end

	pga_side_t side_r;
	assign side_r = side_d[SQ_LAT-1];

	// stage 5: partial products of denominator and mass terms
	logic              v_s5, coinc_s5, dxn_s5, dxp_s5, dyn_s5, dyp_s5;
	logic [D_W-1:0]    adx_s5, ady_s5;
	logic [46:0]       dpp_s5 [6];
	logic [55:0]       gpa_s5 [2];
	logic [55:0]       gpb_s5 [2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= side_r.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			coinc_s5  <= side_r.coinc;
			dxn_s5    <= side_r.dx_neg;
			dxp_s5    <= side_r.dx_pos;
			dyn_s5    <= side_r.dy_neg;
			dyp_s5    <= side_r.dy_pos;
			adx_s5    <= side_r.adx;
			ady_s5    <= side_r.ady;
			dpp_s5[0] <= 47'(side_r.s[21:0])  * 47'(root[24:0]);
			dpp_s5[1] <= 47'(side_r.s[21:0])  * 47'(root[48:25]);
			dpp_s5[2] <= 47'(side_r.s[43:22]) * 47'(root[24:0]);
			dpp_s5[3] <= 47'(side_r.s[43:22]) * 47'(root[48:25]);
			dpp_s5[4] <= 47'(side_r.s[65:44]) * 47'(root[24:0]);
			dpp_s5[5] <= 47'(side_r.s[65:44]) * 47'(root[48:25]);
			gpa_s5[0] <= 56'(grav_q) * 56'(side_r.ma[23:0]);
			gpa_s5[1] <= 56'(grav_q) * 56'(side_r.ma[47:24]);
			gpb_s5[0] <= 56'(grav_q) * 56'(side_r.mb[23:0]);
			gpb_s5[1] <= 56'(grav_q) * 56'(side_r.mb[47:24]);
		end
	end

	// stage 6: denominator s * t and g * mass
	logic              v_s6, coinc_s6, dxn_s6, dxp_s6, dyn_s6, dyp_s6;
	logic [D_W-1:0]    adx_s6, ady_s6;
	logic [DEN_W-1:0]  den_s6;
	logic [GM_W-1:0]   gma_s6, gmb_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			coinc_s6 <= coinc_s5;
			dxn_s6   <= dxn_s5;
			dxp_s6   <= dxp_s5;
			dyn_s6   <= dyn_s5;
			dyp_s6   <= dyp_s5;
			adx_s6   <= adx_s5;
			ady_s6   <= ady_s5;
			den_s6   <= DEN_W'(dpp_s5[0])
				+ (DEN_W'(dpp_s5[1]) << 25)
				+ (DEN_W'(dpp_s5[2]) << 22)
				+ (DEN_W'(dpp_s5[3]) << 47)
				+ (DEN_W'(dpp_s5[4]) << 44)
				+ (DEN_W'(dpp_s5[5]) << 69);
			gma_s6   <= GM_W'(gpa_s5[0]) + (GM_W'(gpa_s5[1]) << 24);
			gmb_s6   <= GM_W'(gpb_s5[0]) + (GM_W'(gpb_s5[1]) << 24);
		end
	end

	// stage 7: numerator partial products
	logic              v_s7, coinc_s7;
	logic [N_COMP-1:0] neg_s7;
	logic [DEN_W-1:0]  den_s7;
	logic [59:0]       np_s7 [N_COMP][3];
	logic [GM_W-1:0]   gm_sel [N_COMP];
	logic [D_W-1:0]    d_sel  [N_COMP];

	assign gm_sel[0] = gmb_s6;
	assign gm_sel[1] = gmb_s6;
	assign gm_sel[2] = gma_s6;
	assign gm_sel[3] = gma_s6;
	assign d_sel[0]  = adx_s6;
	assign d_sel[1]  = ady_s6;
	assign d_sel[2]  = adx_s6;
	assign d_sel[3]  = ady_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			coinc_s7 <= coinc_s6;
			neg_s7   <= {dyp_s6, dxp_s6, dyn_s6, dxn_s6};
			den_s7   <= den_s6;
			for (int c = 0; c < N_COMP; c++) begin
				np_s7[c][0] <= 60'(gm_sel[c][26:0])  * 60'(d_sel[c]);
				np_s7[c][1] <= 60'(gm_sel[c][53:27]) * 60'(d_sel[c]);
				np_s7[c][2] <= 60'(gm_sel[c][79:54]) * 60'(d_sel[c]);
			end
		end
	end

	// stage 8: numerators
	logic              v_s8, coinc_s8;
	logic [N_COMP-1:0] neg_s8;
	logic [DEN_W-1:0]  den_s8;
	logic [NUM_W-1:0]  num_s8 [N_COMP];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			coinc_s8 <= coinc_s7;
			neg_s8   <= neg_s7;
			den_s8   <= den_s7;
			for (int c = 0; c < N_COMP; c++) begin
				num_s8[c] <= NUM_W'(np_s7[c][0])
					+ (NUM_W'(np_s7[c][1]) << 27)
					+ (NUM_W'(np_s7[c][2]) << 54);
			end
		end
	end

	// dividers, one per component
	logic [ACC_W-1:0] acc [N_COMP];

	genvar c;
	for (c = 0; c < N_COMP; c++) begin : g_div
		pga_div u_div (
			.clk (clk),
			.en  (en),
			.num (num_s8[c]),
			.den (den_s8),
			.neg (neg_s8[c]),
			.acc (acc[c])
		);
	end

	pga_tag_t tag_d [DIV_LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIV_LAT; i++) begin
				tag_d[i] <= '0;
			end
		end else if (en) begin
			tag_d[0] <= '{valid: v_s8, coinc: coinc_s8};
			for (int i = 1; i < DIV_LAT; i++) begin
				tag_d[i] <= tag_d[i-1];
			end
		end
	end

	// output register
	logic [OUT_W-1:0] data_q;
	logic             user_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= tag_d[DIV_LAT-1].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			user_q <= tag_d[DIV_LAT-1].coinc;
			data_q <= tag_d[DIV_LAT-1].coinc ? '0 : {acc[3], acc[2], acc[1], acc[0]};
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = data_q;
	assign m_tuser  = user_q;

	// coincident results carry zero accelerations
	a_coinc_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("coincident transfer with nonzero acceleration");

	// the two bodies are never both pulled toward negative x or negative y
	a_opposite: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[31] && m_tdata[95]) && !(m_tdata[63] && m_tdata[127]))
		else $error("both bodies accelerated the same negative direction");

	// an empty output never blocks the input
	a_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

endmodule
